// ===== rtl/integer_to_decimal_ascii_assert.svh =====
// Assertion macros shared by the converter RTL.
`ifndef INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH
`define INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define I2DA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define I2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/i2da_pkg.sv =====
// ---------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants of the integer to decimal ASCII converter.
// ---------------------------------------------------------------------------
package i2da_pkg;

    localparam int VALUE_W    = 31;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4;
    localparam int ASCII_W    = 6;
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [ASCII_W-1:0] ASCII_ZERO = ASCII_W'(48);

    // Cell operation codes
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD  = 2'd0;
    localparam t_cell_op OP_CLEAR = 2'd1;
    localparam t_cell_op OP_BIT   = 2'd2;
    localparam t_cell_op OP_DIGIT = 2'd3;

    typedef logic [BCD_W-1:0] t_bcd;

    // Control broadcast to every digit cell
    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

// ===== rtl/i2da_digit_cell.sv =====
// ---------------------------------------------------------------------------
// i2da_digit_cell
// One BCD digit of the conversion chain: shift-and-add-3 step on binary
// bits, a whole-digit shift toward the top of the chain for output, clear or hold.
// ---------------------------------------------------------------------------
module i2da_digit_cell (
    input  logic                i_clk,
    input  i2da_pkg::t_cell_ctl i_ctl,
    input  logic                i_shift_bit,
    input  i2da_pkg::t_bcd      i_digit,
    output logic                o_shift_bit,
    output i2da_pkg::t_bcd      o_digit
);

    i2da_pkg::t_bcd r_digit;
    i2da_pkg::t_bcd n_digit;
    i2da_pkg::t_bcd w_adj;

    // Correct digits of five and above before the doubling shift
    assign w_adj = (r_digit >= i2da_pkg::BCD_W'(5)) ? r_digit + i2da_pkg::BCD_W'(3) : r_digit;

    always_comb begin
        case (i_ctl.op)
            i2da_pkg::OP_CLEAR: n_digit = '0;
            i2da_pkg::OP_BIT:   n_digit = {w_adj[i2da_pkg::BCD_W-2:0], i_shift_bit};
            i2da_pkg::OP_DIGIT: n_digit = i_digit;
            default:            n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_shift_bit = w_adj[i2da_pkg::BCD_W-1];
    assign o_digit     = r_digit;

endmodule

// ===== rtl/integer_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a nonnegative binary integer to its decimal ASCII digits, most
// significant first, without leading zeros, last flag on the final digit.
// ---------------------------------------------------------------------------
//  Channel   Dir  tdata                      Extra
//  s_axis    in   [30:0] value, [31] zero    -
//  m_axis    out  [5:0] ascii_digit, [7:6] 0 tlast = last
//
//  An item is accepted, then converted one binary bit per cycle through the
//  ten-cell BCD chain; its ten digits then shift out of the top cell one
//  digit per cycle, a shown digit waiting while the output side stalls and
//  leading zeros dropped silently.
//  Reset clears the control; digit cells are cleared when an item is taken.
// ---------------------------------------------------------------------------
`include "integer_to_decimal_ascii_assert.svh"

module integer_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [30:0] value, [31] zero fill
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [5:0] ascii_digit, [7:6] zero fill
    output logic        o_m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [i2da_pkg::BIT_CNT_W-1:0] LAST_BIT =
        i2da_pkg::BIT_CNT_W'(i2da_pkg::VALUE_W - 1);
    localparam logic [i2da_pkg::LEFT_W-1:0] ONE_LEFT = i2da_pkg::LEFT_W'(1);

    logic [1:0]                       r_state, n_state;
    logic [i2da_pkg::VALUE_W-1:0]     r_bin, n_bin;
    logic [i2da_pkg::BIT_CNT_W-1:0]   r_cnt, n_cnt;
    logic [i2da_pkg::LEFT_W-1:0]      r_left, n_left;
    logic                             r_started, n_started;

    i2da_pkg::t_cell_ctl              w_ctl;
    logic                             w_shift [0:i2da_pkg::NUM_DIGITS];
    i2da_pkg::t_bcd                   w_digit [0:i2da_pkg::NUM_DIGITS];
    i2da_pkg::t_bcd                   w_top;
    logic                             w_skip;

    // Feed the bottom of the chain
    assign w_shift[0] = r_bin[i2da_pkg::VALUE_W-1];
    assign w_digit[0] = '0;

    // Digit chain, cell 0 least significant
    for (genvar k = 0; k < i2da_pkg::NUM_DIGITS; k++) begin : g_cell
        i2da_digit_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_shift_bit (w_shift[k]),
            .i_digit     (w_digit[k]),
            .o_shift_bit (w_shift[k+1]),
            .o_digit     (w_digit[k+1])
        );
    end

    assign w_top  = w_digit[i2da_pkg::NUM_DIGITS];
    assign w_skip = !r_started && (w_top == '0) && (r_left != ONE_LEFT);

    // Sequencer: accept, convert bit by bit, emit digits
    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_started = r_started;
        w_ctl.op  = i2da_pkg::OP_HOLD;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_bin    = i_s_axis_tdata[i2da_pkg::VALUE_W-1:0];
                    n_cnt    = '0;
                    w_ctl.op = i2da_pkg::OP_CLEAR;
                    n_state  = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctl.op = i2da_pkg::OP_BIT;
                n_bin    = {r_bin[i2da_pkg::VALUE_W-2:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    n_left    = i2da_pkg::LEFT_W'(i2da_pkg::NUM_DIGITS);
                    n_started = 1'b0;
                    n_state   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_skip) begin
                    w_ctl.op = i2da_pkg::OP_DIGIT;
                    n_left   = r_left - 1'b1;
                end else if (i_m_axis_tready) begin
                    w_ctl.op  = i2da_pkg::OP_DIGIT;
                    n_left    = r_left - 1'b1;
                    n_started = 1'b1;
                    if (r_left == ONE_LEFT) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_left    <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_started <= n_started;
        end
    end

    // Binary shift register holds payload only
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
    end

    // Drive the ports
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_EMIT) && !w_skip;
    assign o_m_axis_tdata  = {2'b00, i2da_pkg::ASCII_ZERO + i2da_pkg::ASCII_W'(w_top)};
    assign o_m_axis_tlast  = (r_left == ONE_LEFT);

    // Ten digits always hold a 31-bit value
    `I2DA_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, r_state == ST_CONV, !w_shift[i2da_pkg::NUM_DIGITS])
    // Only decimal digits leave the block
    `I2DA_ASSERT_IMPL(a_digit_range, i_clk, i_rst_n, o_m_axis_tvalid, w_top <= i2da_pkg::BCD_W'(9))
    // A taken input item starts conversion with nothing shown at the output
    `I2DA_ASSERT_NEXT(a_conv_quiet, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_m_axis_tvalid && !o_s_axis_tready)
    // The final digit of a run frees the input side
    `I2DA_ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, o_s_axis_tready)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench of integer_to_decimal_ascii. Integers go in on the input stream
// and every decimal character that comes out is compared, code and last
// flag, against a run of characters worked out here from the same integer.
// A directed set of powers of ten and the numbers just below them comes
// first, then random integers spread over every digit count, with random
// gaps and stalls on both streams as well as stretches without them.
// ---------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 240;

    localparam logic [i2da_pkg::VALUE_W-1:0] VALUE_MAX = {i2da_pkg::VALUE_W{1'b1}};

    // One decimal character of a run
    typedef struct {
        logic [i2da_pkg::ASCII_W-1:0] code;
        logic                         last;
    } t_dec_char;

    // Expected character runs, oldest first
    class decimal_text_board;
        t_dec_char expected_chars[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Queue the characters of an accepted integer, most significant first
        function void note_value(logic [i2da_pkg::VALUE_W-1:0] value);
            logic [3:0]                   rev_digits[i2da_pkg::NUM_DIGITS];
            logic [i2da_pkg::VALUE_W-1:0] rest;
            int                           count;
            t_dec_char                    ch;
            rest  = value;
            count = 0;
            do begin
                rev_digits[count] = 4'(rest % 10);
                rest  = i2da_pkg::VALUE_W'(rest / 10);
                count++;
            end while (rest != 0 && count < i2da_pkg::NUM_DIGITS);
            for (int k = count - 1; k >= 0; k--) begin
                ch.code = i2da_pkg::ASCII_ZERO + i2da_pkg::ASCII_W'(rev_digits[k]);
                ch.last = (k == 0);
                expected_chars.push_back(ch);
            end
        endfunction

        // Compare one output character with the oldest expected one
        function void check_char(logic [i2da_pkg::ASCII_W-1:0] code, logic last);
            t_dec_char ch;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char code=%0d last=%0b", $time, code, last);
                mismatches++;
            end else begin
                ch = expected_chars.pop_front();
                if (code !== ch.code) begin
                    $display("%0t: char code expected %0d actual %0d",
                             $time, ch.code, code);
                    mismatches++;
                end
                if (last !== ch.last) begin
                    $display("%0t: last flag expected %0b actual %0b",
                             $time, ch.last, last);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;  // [30:0] value, [31] zero fill
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // [5:0] ascii_digit, [7:6] zero fill
    logic        o_m_axis_tlast;

    decimal_text_board board = new();
    int                src_max_gap   = 7;
    int                snk_max_stall = 7;
    int                idle_cycles   = 0;

    integer_to_decimal_ascii dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Offer one integer after a random gap, hold it until accepted
    task automatic send_value(logic [i2da_pkg::VALUE_W-1:0] value);
        int gap;
        gap = $urandom_range(src_max_gap, 0);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, value};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_value(value);
    endtask

    // Hold off the input until every expected character has arrived
    task automatic drain_chars();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Pick a digit count first so short and long numbers both show up
    function automatic logic [i2da_pkg::VALUE_W-1:0] pick_value();
        int          ndigits;
        longint      lo;
        longint      hi;
        ndigits = $urandom_range(11, 1);
        if (ndigits == 11)
            return i2da_pkg::VALUE_W'($urandom());
        lo = 1;
        for (int k = 1; k < ndigits; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndigits == 1) lo = 0;
        if (hi > longint'(VALUE_MAX)) hi = longint'(VALUE_MAX);
        return i2da_pkg::VALUE_W'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    // Output side: random stall before each character
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(snk_max_stall, 0);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Check every accepted character
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_char(o_m_axis_tdata[i2da_pkg::ASCII_W-1:0], o_m_axis_tlast);
    end

    // Count cycles in which neither stream moves an item
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("tb: errors");
        $finish;
    end

    initial begin
        longint pow10;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each power of ten and the number just below it
        pow10 = 1;
        for (int k = 0; k < i2da_pkg::NUM_DIGITS; k++) begin
            send_value(i2da_pkg::VALUE_W'(pow10 - 1));
            send_value(i2da_pkg::VALUE_W'(pow10));
            pow10 = pow10 * 10;
        end
        send_value(VALUE_MAX);
        send_value(31'h2AAA_AAAA);
        send_value(31'h5555_5555);
        drain_chars();

        // Random with gaps and stalls on both sides
        for (int n = 0; n < RANDOM_ITEMS / 2; n++) send_value(pick_value());
        drain_chars();

        // Random at full rate
        src_max_gap   = 0;
        snk_max_stall = 0;
        for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_value(pick_value());

        // Random with a busy sender and a stalling receiver
        snk_max_stall = 7;
        for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_value(pick_value());
        i_s_axis_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
